>>> src/pid_differential_motor_mix_defines.svh
// pid_differential_motor_mix_defines.svh
// Assertion macros for the PID motor mix RTL; expects clk and rst_n in scope.
`ifndef PID_DIFFERENTIAL_MOTOR_MIX_DEFINES_SVH
`define PID_DIFFERENTIAL_MOTOR_MIX_DEFINES_SVH

// same-cycle implication
`define PDM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pdm_pkg.sv
// pdm_pkg.sv
// Shared widths, reset values, register codes, stage control type and count clamp.
// No dependencies.
package pdm_pkg;

  localparam int WINDOWS_PER_SIDE = 8;

  localparam int CNT_W   = 4;
  localparam int ERR_W   = 5;
  localparam int DER_W   = 6;
  localparam int GAIN_W  = 16;
  localparam int SUM_W   = 16;
  localparam int PWR_W   = 7;
  localparam int STEER_W = 16;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 16;

  localparam int PP_W  = GAIN_W + ERR_W;
  localparam int PD_W  = GAIN_W + DER_W;
  localparam int PI_W  = GAIN_W + SUM_W;
  localparam int ACC_W = PI_W + 2;
  localparam int SHIFT = 8;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 16'sd256;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 16'sd0;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 16'sd0;
  localparam logic [PWR_W-1:0]         BASE_RST   = 7'd95;
  localparam logic [PWR_W-1:0]         LIMIT_RST  = 7'd100;

  typedef enum logic [IDX_W-1:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_BASE_POWER  = 3'd3,
    CFG_POWER_LIMIT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic en;   // pipeline advances this cycle
    logic vld;  // stage feeding this unit holds an item
  } stage_ctl_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
    if (32'(c) > 32'(WINDOWS_PER_SIDE)) begin
      return CNT_W'(WINDOWS_PER_SIDE);
    end
    return c;
  endfunction

endpackage

>>> src/pdm_error.sv
// pdm_error.sv
// Error, saturating integral and derivative stage; holds the controller state.
// Depends on pdm_pkg.
module pdm_error (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pdm_pkg::stage_ctl_t                ctl,
  input  logic [pdm_pkg::CNT_W-1:0]          left_count,
  input  logic [pdm_pkg::CNT_W-1:0]          right_count,
  output logic signed [pdm_pkg::ERR_W-1:0]   err_o,
  output logic signed [pdm_pkg::SUM_W-1:0]   sum_o,
  output logic signed [pdm_pkg::DER_W-1:0]   deriv_o
);
  import pdm_pkg::*;

  localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W+1)'((1 << (SUM_W-1)) - 1);
  localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W+1)'(1 << (SUM_W-1));

  // err_r and sum_r double as last_error and error_sum
  logic signed [ERR_W-1:0] err_r,   err_nxt;
  logic signed [SUM_W-1:0] sum_r,   sum_nxt;
  logic signed [DER_W-1:0] deriv_r, deriv_nxt;
  logic signed [SUM_W:0]   sum_wide;

  always_comb begin
    err_nxt   = $signed({1'b0, clamp_count(left_count)})
              - $signed({1'b0, clamp_count(right_count)});
    sum_wide  = (SUM_W+1)'(sum_r) + (SUM_W+1)'(err_nxt);
    if (sum_wide > SUM_MAX) begin
      sum_nxt = SUM_W'(SUM_MAX);
    end else if (sum_wide < SUM_MIN) begin
      sum_nxt = SUM_W'(SUM_MIN);
    end else begin
      sum_nxt = sum_wide[SUM_W-1:0];
    end
    deriv_nxt = DER_W'(err_nxt) - DER_W'(err_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= '0;
      sum_r <= '0;
    end else if (ctl.en && ctl.vld) begin
      err_r <= err_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en && ctl.vld) begin
      deriv_r <= deriv_nxt;
    end
  end

  assign err_o   = err_r;
  assign sum_o   = sum_r;
  assign deriv_o = deriv_r;

endmodule

>>> src/pdm_pid.sv
// pdm_pid.sv
// Gain products (one register stage) then floored, saturated steer value.
// Depends on pdm_pkg.
module pdm_pid (
  input  logic                               clk,
  input  pdm_pkg::stage_ctl_t                ctl_mul,
  input  pdm_pkg::stage_ctl_t                ctl_sum,
  input  logic signed [pdm_pkg::GAIN_W-1:0]  gain_p,
  input  logic signed [pdm_pkg::GAIN_W-1:0]  gain_i,
  input  logic signed [pdm_pkg::GAIN_W-1:0]  gain_d,
  input  logic signed [pdm_pkg::ERR_W-1:0]   err,
  input  logic signed [pdm_pkg::SUM_W-1:0]   sum,
  input  logic signed [pdm_pkg::DER_W-1:0]   deriv,
  output logic signed [pdm_pkg::STEER_W-1:0] steer_o
);
  import pdm_pkg::*;

  localparam int SH_W = ACC_W - SHIFT;
  localparam logic signed [SH_W-1:0] STEER_MAX = SH_W'((1 << (STEER_W-1)) - 1);
  localparam logic signed [SH_W-1:0] STEER_MIN = -SH_W'(1 << (STEER_W-1));

  logic signed [PP_W-1:0]    pp_r, pp_nxt;
  logic signed [PI_W-1:0]    pi_r, pi_nxt;
  logic signed [PD_W-1:0]    pd_r, pd_nxt;
  logic signed [ACC_W-1:0]   acc;
  logic signed [SH_W-1:0]    acc_sh;
  logic signed [STEER_W-1:0] steer_r, steer_nxt;

  always_comb begin
    pp_nxt = PP_W'(gain_p) * PP_W'(err);
    pi_nxt = PI_W'(gain_i) * PI_W'(sum);
    pd_nxt = PD_W'(gain_d) * PD_W'(deriv);
  end

  always_ff @(posedge clk) begin
    if (ctl_mul.en && ctl_mul.vld) begin
      pp_r <= pp_nxt;
      pi_r <= pi_nxt;
      pd_r <= pd_nxt;
    end
  end

  // arithmetic shift of the Q26.8 sum gives the floor
  always_comb begin
    acc    = ACC_W'(pp_r) + ACC_W'(pi_r) + ACC_W'(pd_r);
    acc_sh = acc[ACC_W-1:SHIFT];
    if (acc_sh > STEER_MAX) begin
      steer_nxt = STEER_W'(STEER_MAX);
    end else if (acc_sh < STEER_MIN) begin
      steer_nxt = STEER_W'(STEER_MIN);
    end else begin
      steer_nxt = acc_sh[STEER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_sum.en && ctl_sum.vld) begin
      steer_r <= steer_nxt;
    end
  end

  assign steer_o = steer_r;

endmodule

>>> src/pdm_mix.sv
// pdm_mix.sv
// Differential mix of base power and steer, each side clamped to 0..limit.
// Depends on pdm_pkg.
module pdm_mix (
  input  logic signed [pdm_pkg::STEER_W-1:0] steer,
  input  logic [pdm_pkg::PWR_W-1:0]          base_power,
  input  logic [pdm_pkg::PWR_W-1:0]          power_limit,
  output logic [pdm_pkg::PWR_W-1:0]          left_power,
  output logic [pdm_pkg::PWR_W-1:0]          right_power
);
  import pdm_pkg::*;

  localparam int MIX_W = STEER_W + 2;

  logic signed [MIX_W-1:0] base_s, limit_s, steer_s, left_v, right_v;

  function automatic logic [PWR_W-1:0] clamp_pwr(
    input logic signed [MIX_W-1:0] v,
    input logic signed [MIX_W-1:0] lim
  );
    if (v < 0) begin
      return '0;
    end else if (v > lim) begin
      return lim[PWR_W-1:0];
    end
    return v[PWR_W-1:0];
  endfunction

  always_comb begin
    base_s      = $signed(MIX_W'(base_power));
    limit_s     = $signed(MIX_W'(power_limit));
    steer_s     = MIX_W'(steer);
    left_v      = base_s - steer_s;
    right_v     = base_s + steer_s;
    left_power  = clamp_pwr(left_v, limit_s);
    right_power = clamp_pwr(right_v, limit_s);
  end

endmodule

>>> src/pid_differential_motor_mix.sv
// pid_differential_motor_mix: PID steering with differential motor mix.
// Input channel (in_valid/in_stall) carries left and right line-sensor hit
// counts; each transfer yields exactly one result transfer on the output
// channel (out_valid/out_stall) with both motor powers and the steer value.
// Pipeline: input register, error/integral stage, gain products, steer sum
// and saturation, mix and clamp into the output register. One item is
// taken every cycle unless the output stalls; the product stage is the
// deepest logic.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is dropped.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 gain_p,
// 1 gain_i, 2 gain_d, 3 base_power, 4 power_limit); other indexes are
// ignored. Write only while no items are in flight.
// Synchronous active-low reset empties the pipeline, clears the error
// integral and previous error, and loads gains 1.0/0/0, base 95, limit 100.
// Depends on pdm_pkg, pdm_error, pdm_pid, pdm_mix and the defines header.
`include "pid_differential_motor_mix_defines.svh"

module pid_differential_motor_mix (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pdm_pkg::CNT_W-1:0]          in_left_count,
  input  logic [pdm_pkg::CNT_W-1:0]          in_right_count,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pdm_pkg::PWR_W-1:0]          out_left_power,
  output logic [pdm_pkg::PWR_W-1:0]          out_right_power,
  output logic signed [pdm_pkg::STEER_W-1:0] out_steer_value,
  input  logic                               cfg_we,
  input  logic [pdm_pkg::IDX_W-1:0]          cfg_index,
  input  logic [pdm_pkg::DATA_W-1:0]         cfg_data
);
  import pdm_pkg::*;

  logic signed [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [PWR_W-1:0]         base_r, limit_r;

  logic                     en;
  logic                     vld_a_r, vld_b_r, vld_c_r, vld_d_r, out_valid_r;
  logic [CNT_W-1:0]         left_a_r, right_a_r;
  logic signed [ERR_W-1:0]  err_b;
  logic signed [SUM_W-1:0]  sum_b;
  logic signed [DER_W-1:0]  deriv_b;
  logic signed [STEER_W-1:0] steer_d;
  logic [PWR_W-1:0]         left_nxt, right_nxt;
  logic [PWR_W-1:0]         left_r, right_r;
  logic signed [STEER_W-1:0] steer_r;
  stage_ctl_t               ctl_a, ctl_b, ctl_c;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= GAIN_P_RST;
      gain_i_r <= GAIN_I_RST;
      gain_d_r <= GAIN_D_RST;
      base_r   <= BASE_RST;
      limit_r  <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GAIN_P:      gain_p_r <= $signed(cfg_data[GAIN_W-1:0]);
        CFG_GAIN_I:      gain_i_r <= $signed(cfg_data[GAIN_W-1:0]);
        CFG_GAIN_D:      gain_d_r <= $signed(cfg_data[GAIN_W-1:0]);
        CFG_BASE_POWER:  base_r   <= cfg_data[PWR_W-1:0];
        CFG_POWER_LIMIT: limit_r  <= cfg_data[PWR_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipe advances unless a finished result is held
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r     <= 1'b0;
      vld_b_r     <= 1'b0;
      vld_c_r     <= 1'b0;
      vld_d_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_a_r     <= in_valid;
      vld_b_r     <= vld_a_r;
      vld_c_r     <= vld_b_r;
      vld_d_r     <= vld_c_r;
      out_valid_r <= vld_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      left_a_r  <= in_left_count;
      right_a_r <= in_right_count;
    end
  end

  assign ctl_a = '{en: en, vld: vld_a_r};
  assign ctl_b = '{en: en, vld: vld_b_r};
  assign ctl_c = '{en: en, vld: vld_c_r};

  pdm_error u_error (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl_a),
    .left_count  (left_a_r),
    .right_count (right_a_r),
    .err_o       (err_b),
    .sum_o       (sum_b),
    .deriv_o     (deriv_b)
  );

  pdm_pid u_pid (
    .clk     (clk),
    .ctl_mul (ctl_b),
    .ctl_sum (ctl_c),
    .gain_p  (gain_p_r),
    .gain_i  (gain_i_r),
    .gain_d  (gain_d_r),
    .err     (err_b),
    .sum     (sum_b),
    .deriv   (deriv_b),
    .steer_o (steer_d)
  );

  pdm_mix u_mix (
    .steer       (steer_d),
    .base_power  (base_r),
    .power_limit (limit_r),
    .left_power  (left_nxt),
    .right_power (right_nxt)
  );

  always_ff @(posedge clk) begin
    if (en && vld_d_r) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      steer_r <= steer_d;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_power  = left_r;
  assign out_right_power = right_r;
  assign out_steer_value = steer_r;

  `PDM_ASSERT_NEXT(a_deriv_tracks_err, en && vld_a_r,
    deriv_b == DER_W'(err_b) - DER_W'($past(err_b)), "derivative out of step with error")
  `PDM_ASSERT_NEXT(a_bubble_keeps_state, en && !vld_a_r,
    $stable(sum_b) && $stable(err_b), "bubble changed controller state")
  `PDM_ASSERT_NOW(a_zero_steer_even, out_valid_r && out_steer_value == 16'sd0,
    out_left_power == out_right_power, "zero steer gave unequal powers")

endmodule
